// File: sv/pfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types and constants for the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

  localparam int NUM_FRAMES = 65536;
  localparam int MAP_WORDS  = NUM_FRAMES / 64;
  localparam int AW         = $clog2(MAP_WORDS);
  localparam int CW         = $clog2(NUM_FRAMES) + 1;

  localparam logic [2:0] OP_INIT      = 3'd0;
  localparam logic [2:0] OP_ALLOC     = 3'd1;
  localparam logic [2:0] OP_FREE      = 3'd2;
  localparam logic [2:0] OP_ALLOC_RUN = 3'd3;
  localparam logic [2:0] OP_FREE_RUN  = 3'd4;

  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] frame;
    logic [16:0] run_length;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] found_frame;
    logic [16:0] free_frames;
    logic [16:0] used_frames;
  } rsp_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
  } mem_req_t;

  // mask of bits lo..hi (inclusive) of a 64-bit word
  function automatic logic [63:0] range_mask(input logic [5:0] lo, input logic [5:0] hi);
    logic [63:0] a;
    logic [63:0] b;
    a = {64{1'b1}} << lo;
    b = {64{1'b1}} >> (6'd63 - hi);
    return a & b;
  endfunction

endpackage

// File: sv/pfba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_req_if / pfba_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface pfba_req_if;
  logic          valid;
  logic          ready;
  pfba_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pfba_rsp_if;
  logic          valid;
  logic          ready;
  pfba_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/pfba_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_map_ram
// Frame bitmap storage: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfba_map_ram (
  input  logic                clk,
  input  pfba_pkg::mem_req_t  req,
  output logic [63:0]         rd_data
);

  logic [63:0] mem [pfba_pkg::MAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: sv/pfba_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_seq
// Request sequencer: walks the bitmap word by word (write, read, read-modify-write).
// ----------------------------------------------------------------------------
module pfba_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pfba_pkg::req_t      req,
  input  logic [16:0]         total,
  input  logic [16:0]         reserved,
  input  logic                rsp_ready,
  output logic                busy,
  output logic                done,
  output pfba_pkg::rsp_t      rsp,
  output pfba_pkg::mem_req_t  mreq,
  input  logic [63:0]         rd_data
);

  localparam int AW = pfba_pkg::AW;
  localparam int CW = pfba_pkg::CW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_MARK  = 7'b0001000,
    S_RMW   = 7'b0010000,
    S_CLR   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  pfba_pkg::req_t req_r, req_nxt;
  logic [16:0]   eff_r, eff_nxt;
  logic [16:0]   limit_r, limit_nxt;
  logic [16:0]   free_r, free_nxt;
  logic [AW:0]   addr_r, addr_nxt;      // next word to read / process
  logic          pend_r, pend_nxt;      // read issued last cycle
  logic [16:0]   pos_r, pos_nxt;        // frame index (scan base / walk)
  logic [16:0]   run_r, run_nxt;
  logic [16:0]   rstart_r, rstart_nxt;
  logic [16:0]   left_r, left_nxt;      // frames still to mark/clear
  logic          ok_r, ok_nxt;
  logic [15:0]   found_r, found_nxt;
  logic [CW:0]   sum;

  // bit scan locals
  logic [63:0]   wd;
  logic [16:0]   bpos;
  logic [16:0]   cand;
  logic          seen_used;
  logic [6:0]    last_b;                // offset just past the latest used bit
  logic [16:0]   start_t;
  logic          hit;
  logic [5:0]    hit_bit;
  logic          stop;
  logic [5:0]    lo, hi;
  logic [16:0]   span;
  logic [16:0]   wbase;

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE) && rsp_ready;
  assign rsp.ok = ok_r;
  assign rsp.found_frame = found_r;
  assign rsp.free_frames = free_r;
  assign rsp.used_frames = (free_r >= eff_r) ? 17'd0 : eff_r - free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      pend_r  <= pend_nxt;
    end
    req_r    <= req_nxt;
    eff_r    <= eff_nxt;
    limit_r  <= limit_nxt;
    addr_r   <= addr_nxt;
    pos_r    <= pos_nxt;
    run_r    <= run_nxt;
    rstart_r <= rstart_nxt;
    left_r   <= left_nxt;
    ok_r     <= ok_nxt;
    found_r  <= found_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    eff_nxt    = eff_r;
    limit_nxt  = limit_r;
    free_nxt   = free_r;
    addr_nxt   = addr_r;
    pend_nxt   = 1'b0;
    pos_nxt    = pos_r;
    run_nxt    = run_r;
    rstart_nxt = rstart_r;
    left_nxt   = left_r;
    ok_nxt     = ok_r;
    found_nxt  = found_r;
    mreq       = '0;
    sum        = '0;
    wd         = rd_data;
    cand       = '0;
    seen_used  = 1'b0;
    last_b     = '0;
    start_t    = rstart_r;
    hit        = 1'b0;
    hit_bit    = '0;
    stop       = 1'b0;
    bpos       = '0;
    lo         = '0;
    hi         = 6'd63;
    span       = '0;
    wbase      = {1'b0, addr_r[AW-1:0], 6'd0};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = req;
          eff_nxt   = (total > 17'(pfba_pkg::NUM_FRAMES)) ?
                      17'(pfba_pkg::NUM_FRAMES) : total;
          limit_nxt = {eff_nxt[16:3], 3'd0};
          ok_nxt    = 1'b0;
          found_nxt = '0;
          addr_nxt  = '0;
          pos_nxt   = '0;
          run_nxt   = '0;
          rstart_nxt = '0;
          priority case (req.op)
            pfba_pkg::OP_INIT: state_nxt = S_INIT;
            pfba_pkg::OP_ALLOC: begin
              if (limit_nxt == 17'd0) state_nxt = S_DONE;
              else state_nxt = S_SCAN;
            end
            pfba_pkg::OP_ALLOC_RUN: begin
              if (req.run_length == 17'd0 || eff_nxt == 17'd0) state_nxt = S_DONE;
              else state_nxt = S_SCAN;
            end
            pfba_pkg::OP_FREE: begin
              ok_nxt = 1'b1;
              if ({1'b0, req.frame} < eff_nxt) begin
                pos_nxt  = {1'b0, req.frame};
                left_nxt = 17'd1;
                state_nxt = S_CLR;
              end else begin
                state_nxt = S_DONE;
              end
            end
            pfba_pkg::OP_FREE_RUN: begin
              ok_nxt   = 1'b1;
              pos_nxt  = {1'b0, req.frame};
              left_nxt = req.run_length;
              sum = (CW+1)'(free_r) + (CW+1)'(req.run_length);
              free_nxt = (sum > (CW+1)'(eff_nxt)) ? eff_nxt : sum[16:0];
              state_nxt = (req.run_length == 17'd0) ? S_DONE : S_CLR;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // write every word: reserved bits set, the rest clear
      S_INIT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = addr_r[AW-1:0];
        if ({1'b0, reserved} >= {1'b0, wbase} + 18'd64) begin
          mreq.wr_data = '1;
        end else if (reserved > wbase) begin
          mreq.wr_data = pfba_pkg::range_mask(6'd0, 6'(reserved - wbase - 17'd1));
        end else begin
          mreq.wr_data = '0;
        end
        addr_nxt = addr_r + 1'b1;
        if (addr_r == (AW+1)'(pfba_pkg::MAP_WORDS - 1)) begin
          free_nxt  = (reserved >= eff_r) ? 17'd0 : eff_r - reserved;
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      // issue a word read, then examine the returned word
      S_SCAN: begin
        if (!pend_r) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = addr_r[AW-1:0];
          pend_nxt     = 1'b1;
        end else begin
          for (int b = 0; b < 64; b++) begin
            bpos = wbase + 17'(b);
            if (!stop && !hit) begin
              if (req_r.op == pfba_pkg::OP_ALLOC) begin
                if (bpos >= limit_r) stop = 1'b1;
                else if (!wd[b]) begin
                  hit = 1'b1;
                  hit_bit = 6'(b);
                  start_t = bpos;
                end
              end else begin
                if (bpos >= eff_r) stop = 1'b1;
                else if (wd[b]) begin
                  seen_used = 1'b1;
                  last_b    = 7'(b + 1);
                end else begin
                  // run length ending here, from the latest used bit or the carried run
                  cand = seen_used ? (17'(b + 1) - {10'd0, last_b})
                                   : (run_r + 17'(b + 1));
                  if (cand == req_r.run_length) begin
                    hit = 1'b1;
                    if (seen_used) start_t = wbase + {10'd0, last_b};
                    else if (run_r == 17'd0) start_t = wbase;
                    else start_t = rstart_r;
                  end
                end
              end
            end
          end
          if (seen_used) begin
            run_nxt    = 17'd64 - {10'd0, last_b};
            rstart_nxt = wbase + {10'd0, last_b};
          end else begin
            run_nxt    = run_r + 17'd64;
            rstart_nxt = (run_r == 17'd0) ? wbase : rstart_r;
          end
          if (hit && req_r.op == pfba_pkg::OP_ALLOC) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = addr_r[AW-1:0];
            mreq.wr_data = wd | (64'd1 << hit_bit);
            ok_nxt    = 1'b1;
            found_nxt = start_t[15:0];
            free_nxt  = (free_r == 17'd0) ? 17'd0 : free_r - 17'd1;
            state_nxt = S_DONE;
          end else if (hit) begin
            ok_nxt    = 1'b1;
            found_nxt = start_t[15:0];
            free_nxt  = (req_r.run_length >= free_r) ? 17'd0 : free_r - req_r.run_length;
            pos_nxt   = start_t;
            left_nxt  = req_r.run_length;
            state_nxt = S_MARK;
          end else if (stop || addr_r == (AW+1)'(pfba_pkg::MAP_WORDS - 1)) begin
            state_nxt = S_DONE;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
      end

      // set or clear a span of bits, one word per read-modify-write
      S_MARK, S_CLR: begin
        if (!pend_r) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = pos_r[AW+5:6];
          pend_nxt     = 1'b1;
        end else begin
          lo   = pos_r[5:0];
          span = 17'd64 - {11'd0, lo};
          if (left_r < span) hi = 6'(lo + left_r[5:0] - 6'd1);
          else hi = 6'd63;
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = pos_r[AW+5:6];
          mreq.wr_data = (state_r == S_MARK) ? (wd | pfba_pkg::range_mask(lo, hi))
                                             : (wd & ~pfba_pkg::range_mask(lo, hi));
          if (state_r == S_CLR && req_r.op == pfba_pkg::OP_FREE) begin
            free_nxt = (free_r >= eff_r) ? eff_r : free_r + 17'd1;
          end
          if (left_r <= span || pos_r + span >= 17'(pfba_pkg::NUM_FRAMES)) begin
            state_nxt = S_DONE;
          end else begin
            left_nxt = left_r - span;
            pos_nxt  = pos_r + span;
          end
        end
      end

      // hold the result until the output register can take it
      S_DONE: begin
        if (rsp_ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: sv/page_frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core
// Page frame allocator over a 64-bit-word frame bitmap held in block RAM.
//
//  channel | dir | payload
//  in_     | in  | op, frame, run_length
//  out_    | out | ok, found_frame, free_frames, used_frames
//  cfg_    | in  | total_frames (0), reserved_frames (1)
//
// One request at a time. Init writes all 1024 map words. Searches read and
// examine each map word scanned in turn; run marking and freeing read and
// rewrite each word touched. The single RAM port pair sets the pace.
// Synchronous active-low reset clears control and count; the map is
// undefined until an init. The result register holds while
// out_ready is low and the next request is taken meanwhile; that request
// then waits at completion until the register is free.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_core (
  input  logic         clk,
  input  logic         rst_n,
  pfba_req_if.sink     in_ch,
  pfba_rsp_if.source   out_ch,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [16:0]  cfg_wdata
);

  logic [16:0]          total_r, reserved_r;
  logic                 busy, done, start;
  pfba_pkg::rsp_t       rsp, out_r;
  logic                 oval_r;
  pfba_pkg::mem_req_t   mreq;
  logic [63:0]          rd_data;
  logic                 done_ok;

  assign in_ch.ready  = !busy;
  assign start        = in_ch.valid && in_ch.ready;
  assign out_ch.valid = oval_r;
  assign out_ch.data  = out_r;

  // hold completion while the previous result is still waiting
  assign done_ok = !oval_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= 17'd65536;
      reserved_r <= 17'd256;
      oval_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pfba_pkg::CFG_TOTAL:    total_r    <= cfg_wdata;
          pfba_pkg::CFG_RESERVED: reserved_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (done) oval_r <= 1'b1;
      else if (out_ch.ready) oval_r <= 1'b0;
    end
    if (done) out_r <= rsp;
  end

  pfba_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (in_ch.data),
    .total     (total_r),
    .reserved  (reserved_r),
    .rsp_ready (done_ok),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .mreq      (mreq),
    .rd_data   (rd_data)
  );

  pfba_map_ram u_ram (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the page frame bitmap allocator core. Requests are
// driven over the valid/ready input channel; a scoreboard keeps its own copy
// of the frame bitmap and free count, predicts every result and compares it
// field by field with what the core returns. Several frame totals and
// reservations are exercised, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT_CYCLES = 8_000_000;

  class alloc_scoreboard;
    bit [63:0]   fmap [pfba_pkg::MAP_WORDS];
    int unsigned free_cnt;
    int unsigned tot_reg;
    int unsigned res_reg;
    pfba_pkg::rsp_t expected_q [$];
    int          fails;

    function new();
      free_cnt = 0;
      tot_reg  = 65536;
      res_reg  = 256;
      fails    = 0;
      foreach (fmap[w]) fmap[w] = '0;
    endfunction

    function int unsigned eff_total();
      return (tot_reg < pfba_pkg::NUM_FRAMES) ? tot_reg : pfba_pkg::NUM_FRAMES;
    endfunction

    function void set_reg(logic idx, int unsigned val);
      if (idx == pfba_pkg::CFG_TOTAL) tot_reg = val & 17'h1FFFF;
      else res_reg = val & 17'h1FFFF;
    endfunction

    function void count_down(int unsigned n);
      free_cnt = (n >= free_cnt) ? 0 : free_cnt - n;
    endfunction

    function void count_up(int unsigned n);
      longint unsigned s;
      s = longint'(free_cnt) + n;
      free_cnt = (s > eff_total()) ? eff_total() : int'(s);
    endfunction

    function void note_request(pfba_pkg::req_t rq);
      pfba_pkg::rsp_t rs;
      int unsigned eff, lim, idx, run, start, i, w, b, len;
      bit          ok, done;
      eff   = eff_total();
      len   = rq.run_length;
      ok    = 0;
      idx   = 0;
      start = 0;
      case (rq.op)
        pfba_pkg::OP_INIT: begin
          foreach (fmap[k]) fmap[k] = '0;
          for (i = 0; i < res_reg && i < pfba_pkg::NUM_FRAMES; i++)
            fmap[i >> 6][i & 63] = 1'b1;
          free_cnt = (res_reg >= eff) ? 0 : eff - res_reg;
          ok = 1;
        end
        pfba_pkg::OP_ALLOC: begin
          lim  = (eff / 8) * 8;
          done = 0;
          for (w = 0; w * 64 < lim && !done; w++) begin
            if (fmap[w] != '1) begin
              done = 1;
              for (b = 0; b < 64; b++) if (!fmap[w][b]) break;
              if (w * 64 + b < lim) begin
                fmap[w][b] = 1'b1;
                count_down(1);
                ok  = 1;
                idx = w * 64 + b;
              end
            end
          end
        end
        pfba_pkg::OP_FREE: begin
          if (rq.frame < eff) begin
            fmap[rq.frame >> 6][rq.frame & 63] = 1'b0;
            count_up(1);
          end
          ok = 1;
        end
        pfba_pkg::OP_ALLOC_RUN: begin
          run = 0;
          i   = 0;
          while (len != 0 && i < eff && !ok) begin
            // skip fully used words in one step
            if ((i & 63) == 0 && fmap[i >> 6] == '1) begin
              run = 0;
              i += 64;
            end else begin
              if (fmap[i >> 6][i & 63]) run = 0;
              else begin
                if (run == 0) start = i;
                run++;
                if (run == len) begin
                  for (int j = start; j <= i; j++) fmap[j >> 6][j & 63] = 1'b1;
                  count_down(len);
                  ok  = 1;
                  idx = start;
                end
              end
              i++;
            end
          end
        end
        pfba_pkg::OP_FREE_RUN: begin
          for (i = 0; i < len; i++) begin
            w = rq.frame + i;
            if (w < pfba_pkg::NUM_FRAMES) fmap[w >> 6][w & 63] = 1'b0;
          end
          count_up(len);
          ok = 1;
        end
        default: ;
      endcase
      rs.ok          = ok;
      rs.found_frame = idx[15:0];
      rs.free_frames = free_cnt[16:0];
      rs.used_frames = (free_cnt >= eff) ? 17'd0 : 17'(eff - free_cnt);
      expected_q.push_back(rs);
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fails++;
    endfunction

    function void check_result(pfba_pkg::rsp_t rs);
      pfba_pkg::rsp_t ex;
      if (expected_q.size() == 0) begin
        report("unexpected result, ok", rs.ok, 0);
        return;
      end
      ex = expected_q.pop_front();
      if (rs.ok !== ex.ok) report("ok", rs.ok, ex.ok);
      if (rs.found_frame !== ex.found_frame) report("found_frame", rs.found_frame,
                                                    ex.found_frame);
      if (rs.free_frames !== ex.free_frames) report("free_frames", rs.free_frames,
                                                    ex.free_frames);
      if (rs.used_frames !== ex.used_frames) report("used_frames", rs.used_frames,
                                                    ex.used_frames);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [16:0] cfg_wdata;

  pfba_req_if in_ch ();
  pfba_rsp_if out_ch ();

  page_frame_bitmap_allocator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  alloc_scoreboard sb = new();
  bit              idling = 1;
  int              long_stall_asks = 0;
  int              cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // observe both channels at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // result receiver: random back-pressure plus one long hold-off
  initial begin
    int hold;
    int seen;
    hold = 0;
    seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (seen != long_stall_asks) begin
        seen = long_stall_asks;
        hold = 3000;
      end else if (hold == 0 && idling && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 8);
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [2:0] op, int unsigned frame, int unsigned len);
    pfba_pkg::req_t rq;
    rq.op         = op;
    rq.frame      = frame[15:0];
    rq.run_length = len[16:0];
    if (idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= rq;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[16:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(int unsigned tot, int unsigned res);
    drain();
    repeat (20) @(posedge clk);
    write_reg(pfba_pkg::CFG_TOTAL, tot);
    write_reg(pfba_pkg::CFG_RESERVED, res);
  endtask

  task automatic random_request();
    int unsigned sel, eff, frame, len;
    logic [2:0]  op;
    eff = sb.eff_total();
    sel = $urandom_range(0, 99);
    if (sel < 4) op = pfba_pkg::OP_INIT;
    else if (sel < 34) op = pfba_pkg::OP_ALLOC;
    else if (sel < 54) op = pfba_pkg::OP_FREE;
    else if (sel < 79) op = pfba_pkg::OP_ALLOC_RUN;
    else if (sel < 94) op = pfba_pkg::OP_FREE_RUN;
    else op = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 1) == 0) frame = $urandom_range(0, (eff == 0) ? 0 : eff - 1);
    else frame = $urandom_range(0, 65535);
    sel = $urandom_range(0, 9);
    if (sel < 7) len = $urandom_range(0, 20);
    else if (sel < 9) len = $urandom_range(0, 300);
    else len = $urandom_range(0, 131071);
    send_request(op, frame, len);
  endtask

  int unsigned phase_tot [9] = '{65536, 1024, 64, 0, 131071, 1027, 999, 200, 4100};
  int unsigned phase_res [9] = '{256, 17, 0, 0, 65536, 2000, 5, 131071, 64};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_index   = pfba_pkg::CFG_TOTAL;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset configuration, init first so the map is defined
    send_request(pfba_pkg::OP_INIT, 0, 0);
    send_request(pfba_pkg::OP_ALLOC, 0, 0);
    send_request(pfba_pkg::OP_ALLOC_RUN, 0, 0);
    send_request(pfba_pkg::OP_ALLOC_RUN, 0, 1);
    send_request(pfba_pkg::OP_ALLOC_RUN, 0, 65536);
    send_request(pfba_pkg::OP_ALLOC_RUN, 0, 131071);
    send_request(pfba_pkg::OP_ALLOC_RUN, 0, 300);
    send_request(pfba_pkg::OP_FREE, 0, 0);
    send_request(pfba_pkg::OP_FREE, 65535, 0);
    send_request(pfba_pkg::OP_FREE, 65535, 0);
    send_request(pfba_pkg::OP_FREE_RUN, 65535, 131071);
    send_request(pfba_pkg::OP_FREE_RUN, 0, 65536);
    send_request(pfba_pkg::OP_ALLOC, 0, 0);
    send_request(3'd5, 0, 0);
    send_request(3'd6, 65535, 131071);
    send_request(3'd7, 1234, 7);
    send_request(pfba_pkg::OP_INIT, 0, 0);
    send_request(pfba_pkg::OP_ALLOC_RUN, 65535, 65280);
    send_request(pfba_pkg::OP_ALLOC, 0, 0);

    foreach (phase_tot[p]) begin
      if (p == 8) idling = 0;
      configure(phase_tot[p], phase_res[p]);
      send_request(pfba_pkg::OP_INIT, 0, 0);
      for (int n = 0; n < 62; n++) begin
        if (p == 1 && n == 10) long_stall_asks++;
        if (p == 2 && n == 30) drain();
        random_request();
      end
    end

    drain();
    repeat (2200) @(posedge clk);
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/pfba_pkg.sv
sv/pfba_if.sv
sv/pfba_map_ram.sv
sv/pfba_seq.sv
sv/page_frame_bitmap_allocator_core.sv
sim/testbench.sv
